### hw/rtl/ltsc_pkg.sv
// Package for the tile slot cache: sizes, command codes and the cell control word.
package ltsc_pkg;
    localparam int NumSlotsDef = 16;
    localparam int MaxResults = 16;
    localparam int CoordW = 32;
    localparam int StampW = 64;
    localparam int SlotW = 4;

    localparam logic [1:0] CmdAcquire = 2'd0;
    localparam logic [1:0] CmdRelease = 2'd1;
    localparam logic [1:0] CmdFlush = 2'd2;

    // Control word broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                write;    // claim or refresh the addressed cell
        logic                set_key;  // also load the key (miss)
        logic                unpin;    // clear the pin of the addressed cell
        logic [5:0]          addr;
        logic [CoordW-1:0]   key_x;
        logic [CoordW-1:0]   key_y;
        logic [StampW-1:0]   stamp;
    } t_cell_ctrl;

    // Data passed down the chain during a scan, one cell per cycle.
    typedef struct packed {
        logic                act;      // a scan word is moving
        logic [5:0]          idx;      // index of the cell that receives it
        logic                hit_f;
        logic [5:0]          hit_i;
        logic                emp_f;
        logic [5:0]          emp_i;
        logic                lru_f;
        logic [5:0]          lru_i;
        logic [StampW-1:0]   lru_s;
        logic [CoordW-1:0]   lru_x;
        logic [CoordW-1:0]   lru_y;
    } t_scan;
endpackage

### hw/rtl/lru_tile_slot_cache.sv
// Top level of the tile slot cache: sequencer, output register and the chain of cells.
//
// Usage: drive i_cmd and its fields with start high while busy is low; the
// word is taken at that edge. Acquire launches a scan word into the chain on
// the cycle after acceptance, once the query key is registered. The word
// passes one cell per cycle. The single result (o_valid strobe, o_last set)
// is registered as the word leaves the last cell, and it is shown in the
// last busy cycle, while the chosen cell is written (none on overflow). Busy
// stays high through scan and write, so acquires do not overlap.
// Release and command 3 keep busy high for one cycle and give no result.
// Flush walks the cells one per cycle and strobes one write-back word per
// valid slot, at most MaxResults, with o_last on the final one. Busy stays
// high until every cell is walked or MaxResults words are out.
// Results are strobed for one cycle and the receiver cannot stall them.
// Reset (synchronous, active low) empties and unpins every slot and clears
// the tick; the block is ready on the next cycle.
module lru_tile_slot_cache #(
    parameter int NUM_SLOTS = ltsc_pkg::NumSlotsDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_cmd,
    input  logic signed [ltsc_pkg::CoordW-1:0] i_tile_x,
    input  logic signed [ltsc_pkg::CoordW-1:0] i_tile_y,
    input  logic [ltsc_pkg::SlotW-1:0]    i_release_slot,
    output logic                          o_valid,
    output logic [ltsc_pkg::SlotW-1:0]    o_slot,
    output logic                          o_hit,
    output logic                          o_fill_needed,
    output logic                          o_writeback,
    output logic signed [ltsc_pkg::CoordW-1:0] o_wb_x,
    output logic signed [ltsc_pkg::CoordW-1:0] o_wb_y,
    output logic                          o_overflow,
    output logic                          o_last
);
    import ltsc_pkg::*;

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StScan = 3'd1;
    localparam logic [2:0] StDone = 3'd2;
    localparam logic [2:0] StFlush = 3'd3;
    localparam logic [2:0] StWait = 3'd4;
    localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    t_scan             scan [NUM_SLOTS+1];
    logic              cv [NUM_SLOTS];
    logic [CoordW-1:0] cx [NUM_SLOTS];
    logic [CoordW-1:0] cy [NUM_SLOTS];
    t_cell_ctrl        ctrl;

    logic [2:0]        r_st;
    logic [CoordW-1:0] r_qx, r_qy;
    logic [StampW-1:0] r_tick;
    logic [6:0]        r_fi;
    logic [4:0]        r_cnt;
    logic              r_pend;
    logic [5:0]        r_pslot;
    logic              r_go;
    logic [IdxW-1:0]   fidx;
    logic              fend;
    t_scan             res;

    logic              n_valid, n_hit, n_fill, n_wb, n_ovf, n_last, n_pend;
    logic [SlotW-1:0]  n_slot;
    logic [5:0]        n_pslot;
    logic [CoordW-1:0] n_wbx, n_wby;

    assign res = scan[NUM_SLOTS];
    assign fidx = r_fi[IdxW-1:0];

    always_comb begin
        scan[0] = '0;
        scan[0].act = r_go;
        scan[0].idx = '0;
    end

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        ltsc_cell #(.Index(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl),
            .i_qx(r_qx), .i_qy(r_qy),
            .i_scan(scan[g]), .o_scan(scan[g+1]),
            .o_valid(cv[g]), .o_x(cx[g]), .o_y(cy[g])
        );
    end

    always_comb begin
        ctrl = '0;
        ctrl.stamp = r_tick;
        ctrl.key_x = r_qx;
        ctrl.key_y = r_qy;
        ctrl.addr  = 6'h3F;
        if (r_st == StIdle && start && i_cmd == CmdRelease
            && {3'b0, i_release_slot} < 7'(NUM_SLOTS)) begin
            ctrl.unpin = 1'b1;
            ctrl.addr  = {2'b0, i_release_slot};
        end else if (r_st == StDone && r_pend) begin
            ctrl.write   = 1'b1;
            ctrl.addr    = r_pslot;
            ctrl.set_key = ~o_hit;
        end
    end

    assign busy = (r_st != StIdle);
    assign fend = (r_fi >= 7'(NUM_SLOTS)) || (r_cnt == 5'(MaxResults));

    // Looks ahead for the next valid cell to place o_last on a flush word.
    function automatic logic more_valid(input logic [6:0] from, input logic [4:0] cnt,
                                        input logic v [NUM_SLOTS]);
        logic m;
        m = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++)
            if (7'(k) > from && v[k]) m = 1'b1;
        return m && (cnt + 5'd1 < 5'(MaxResults));
    endfunction

    always_comb begin
        n_valid = 1'b0;
        n_slot  = o_slot;
        n_hit   = o_hit;
        n_fill  = o_fill_needed;
        n_wb    = o_writeback;
        n_wbx   = o_wb_x;
        n_wby   = o_wb_y;
        n_ovf   = o_overflow;
        n_last  = o_last;
        n_pend  = 1'b0;
        n_pslot = r_pslot;
        if (r_st == StScan && res.act) begin
            n_valid = 1'b1;
            n_last  = 1'b1;
            n_ovf   = 1'b0;
            n_hit   = 1'b0;
            n_fill  = 1'b1;
            n_wb    = 1'b0;
            n_wbx   = '0;
            n_wby   = '0;
            n_pend  = 1'b1;
            if (res.hit_f) begin
                n_pslot = res.hit_i;
                n_hit   = 1'b1;
                n_fill  = 1'b0;
            end else if (res.emp_f) begin
                n_pslot = res.emp_i;
            end else if (res.lru_f) begin
                n_pslot = res.lru_i;
                n_wb    = 1'b1;
                n_wbx   = res.lru_x;
                n_wby   = res.lru_y;
            end else begin
                n_pend  = 1'b0;
                n_pslot = '0;
                n_fill  = 1'b0;
                n_ovf   = 1'b1;
            end
            n_slot = n_pslot[3:0];
        end else if (r_st == StFlush && !fend && cv[fidx]) begin
            n_valid = 1'b1;
            n_slot  = SlotW'(fidx);
            n_hit   = 1'b0;
            n_fill  = 1'b0;
            n_ovf   = 1'b0;
            n_wb    = 1'b1;
            n_wbx   = cx[fidx];
            n_wby   = cy[fidx];
            n_last  = ~more_valid(r_fi, r_cnt, cv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= StIdle;
            r_tick  <= '0;
            o_valid <= 1'b0;
            r_pend  <= 1'b0;
            r_go    <= 1'b0;
        end else begin
            o_valid <= n_valid;
            r_pend  <= n_pend;
            r_go    <= (r_st == StIdle) && start && (i_cmd == CmdAcquire);
            if (r_st == StDone && r_pend) r_tick <= r_tick + 64'd1;
            case (r_st)
                StIdle: if (start) begin
                    r_qx <= i_tile_x;
                    r_qy <= i_tile_y;
                    r_fi <= '0;
                    r_cnt <= '0;
                    case (i_cmd)
                        CmdAcquire: r_st <= StScan;
                        CmdFlush:   r_st <= StFlush;
                        default:    r_st <= StWait;
                    endcase
                end
                StScan: if (res.act) r_st <= StDone;
                StDone: r_st <= StIdle;
                StFlush: begin
                    if (fend) r_st <= StIdle;
                    else begin
                        if (cv[fidx]) r_cnt <= r_cnt + 5'd1;
                        r_fi <= r_fi + 7'd1;
                    end
                end
                default: r_st <= StIdle;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        o_slot        <= n_slot;
        o_hit         <= n_hit;
        o_fill_needed <= n_fill;
        o_writeback   <= n_wb;
        o_wb_x        <= n_wbx;
        o_wb_y        <= n_wby;
        o_overflow    <= n_ovf;
        o_last        <= n_last;
        r_pslot       <= n_pslot;
    end

    a_hit_nofill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> !o_fill_needed && !o_writeback) else $error("hit with fill");
    a_ovf_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> !o_hit && !o_fill_needed && o_last) else $error("bad ovf");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy) else $error("flush ended early");
endmodule

### hw/rtl/ltsc_cell.sv
// One slot cell: holds a key, stamp and flags and updates the scan word passing through.
module ltsc_cell #(
    parameter int Index = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ltsc_pkg::t_cell_ctrl i_ctrl,
    input  logic [ltsc_pkg::CoordW-1:0] i_qx,
    input  logic [ltsc_pkg::CoordW-1:0] i_qy,
    input  ltsc_pkg::t_scan     i_scan,
    output ltsc_pkg::t_scan     o_scan,
    output logic                o_valid,
    output logic [ltsc_pkg::CoordW-1:0] o_x,
    output logic [ltsc_pkg::CoordW-1:0] o_y
);
    import ltsc_pkg::*;

    logic              r_valid, r_pin;
    logic [CoordW-1:0] r_x, r_y;
    logic [StampW-1:0] r_stamp;
    t_scan             r_scan, n_scan;
    logic              here;

    assign here = (i_ctrl.addr == 6'(Index));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pin   <= 1'b0;
            r_x     <= '0;
            r_y     <= '0;
            r_stamp <= '0;
        end else if (here) begin
            if (i_ctrl.write) begin
                r_pin   <= 1'b1;
                r_stamp <= i_ctrl.stamp;
                if (i_ctrl.set_key) begin
                    r_valid <= 1'b1;
                    r_x     <= i_ctrl.key_x;
                    r_y     <= i_ctrl.key_y;
                end
            end else if (i_ctrl.unpin) begin
                r_pin <= 1'b0;
            end
        end
    end

    always_comb begin
        n_scan = i_scan;
        if (i_scan.act && i_scan.idx == 6'(Index)) begin
            n_scan.idx = i_scan.idx + 6'd1;
            if (!i_scan.hit_f && r_valid && r_x == i_qx && r_y == i_qy) begin
                n_scan.hit_f = 1'b1;
                n_scan.hit_i = 6'(Index);
            end
            if (!i_scan.emp_f && !r_valid) begin
                n_scan.emp_f = 1'b1;
                n_scan.emp_i = 6'(Index);
            end
            // Less-or-equal so that the highest index wins a tie.
            if (!r_pin && (!i_scan.lru_f || r_stamp <= i_scan.lru_s)) begin
                n_scan.lru_f = 1'b1;
                n_scan.lru_i = 6'(Index);
                n_scan.lru_s = r_stamp;
                n_scan.lru_x = r_x;
                n_scan.lru_y = r_y;
            end
        end else begin
            n_scan.act = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_scan.act <= 1'b0;
        else          r_scan.act <= n_scan.act;
        r_scan.idx   <= n_scan.idx;
        r_scan.hit_f <= n_scan.hit_f;
        r_scan.hit_i <= n_scan.hit_i;
        r_scan.emp_f <= n_scan.emp_f;
        r_scan.emp_i <= n_scan.emp_i;
        r_scan.lru_f <= n_scan.lru_f;
        r_scan.lru_i <= n_scan.lru_i;
        r_scan.lru_s <= n_scan.lru_s;
        r_scan.lru_x <= n_scan.lru_x;
        r_scan.lru_y <= n_scan.lru_y;
    end

    assign o_scan  = r_scan;
    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
endmodule
